### hw/rtl/ppa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared constants, types and the arctangent table for the polar position
// accumulator.
// ----------------------------------------------------------------------------
package ppa_pkg;

   localparam int GUARD = 4;
   localparam logic [31:0] INVK = 32'd2608131497;

   typedef struct packed {
      logic valid;
      logic vec;
   } ppa_ctl_type;

   // atan(2^-i) as a fraction of a full turn, times 2^32
   function automatic logic [31:0] atan_turn(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         25: v = 32'd20;
         26: v = 32'd10;
         27: v = 32'd5;
         28: v = 32'd3;
         29: v = 32'd1;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/ppa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_cell
// One CORDIC micro-rotation with a fixed shift, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module ppa_cell
   import ppa_pkg::*;
#(
   parameter int CW    = 40,
   parameter int ZW    = 34,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppa_ctl_type          ctl_i,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic signed [ZW-1:0] z_i,
   output ppa_ctl_type          ctl_o,
   output logic signed [CW-1:0] x_o,
   output logic signed [CW-1:0] y_o,
   output logic signed [ZW-1:0] z_o
);

   localparam logic [31:0] ATAN = atan_turn(SHIFT);

   ppa_ctl_type          ctl_ff;
   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic                 ccw;

   always_comb begin
      at  = ZW'(ATAN);
      dx  = y_i >>> SHIFT;
      dy  = x_i >>> SHIFT;
      // vectoring drives y toward zero, rotation drives z toward zero
      ccw = ctl_i.vec ? (y_i <= 0) : (z_i >= 0);
      if (ccw) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - at;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign ctl_o = ctl_ff;
   assign x_o   = x_ff;
   assign y_o   = y_ff;
   assign z_o   = z_ff;

endmodule

### hw/rtl/polar_position_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_position_accumulator_unit
// Dead-reckoning position in polar form, updated by polar displacements
// through a chain of CORDIC cells.
// ----------------------------------------------------------------------------
// each item makes two trips through the cell chain and three passes through the
// scaler; a sum on an axis skips the vectoring trip and the last scaler pass
// flow: one item at a time; the next item is taken while the result waits
// reset: synchronous, clears the position to the origin and empties the chain
module polar_position_accumulator_unit
   import ppa_pkg::*;
#(
   parameter int RADIUS_BITS = 32,
   parameter int ANGLE_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [RADIUS_BITS-1:0] req_step_radius,
   input  logic [ANGLE_BITS-1:0]  req_step_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [RADIUS_BITS-1:0] rsp_position_radius,
   output logic [ANGLE_BITS-1:0]  rsp_position_angle,
   output logic                   rsp_saturated
);

   localparam int ITERS = ANGLE_BITS + 8;
   localparam int CW    = RADIUS_BITS + GUARD + 4;
   localparam int ZW    = 34;
   localparam int OPW   = (CW > 32) ? CW : 33;
   localparam int MW    = CW + 1;
   localparam int RW    = MW + 1 - GUARD;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_ROT  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_VEC  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam logic [1:0] PH_POS  = 2'd0;
   localparam logic [1:0] PH_STEP = 2'd1;
   localparam logic [1:0] PH_MAG  = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic [RADIUS_BITS-1:0] step_r_ff, step_r_in, cur_r_ff, cur_r_in;
   logic [ANGLE_BITS-1:0]  step_a_ff, step_a_in, cur_a_ff, cur_a_in;
   logic [OPW-1:0]         op_ff, op_in;
   logic [63:0]            prod_lo_ff;
   logic [OPW-1:0]         prod_hi_ff;
   logic signed [CW-1:0]   x1_ff, x1_in, y1_ff, y1_in, sx_ff, sx_in, sy_ff, sy_in;
   logic                   have1_ff, have1_in;
   logic [MW-1:0]          mag_ff, mag_in;
   logic [31:0]            z32_ff, z32_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   logic [RADIUS_BITS-1:0] rsp_r_ff, rsp_r_in;
   logic [ANGLE_BITS-1:0]  rsp_a_ff, rsp_a_in;

   ppa_ctl_type            cc   [0:ITERS];
   logic signed [CW-1:0]   cx   [0:ITERS];
   logic signed [CW-1:0]   cy   [0:ITERS];
   logic signed [ZW-1:0]   cz   [0:ITERS];

   logic [OPW-1:0]         scaled;
   logic signed [CW-1:0]   rs;
   logic [ANGLE_BITS-1:0]  ang_sel;
   logic [RW-1:0]          rad_sh;
   logic [MW:0]            rad_full;
   logic [32:0]            asum;
   logic                   sat_now, accept, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scaled   = prod_hi_ff + OPW'(prod_lo_ff[63:32]);
   assign rs       = CW'(scaled);
   assign ang_sel  = (phase_ff == PH_POS) ? cur_a_ff : step_a_ff;

   always_comb begin
      rad_full = (MW+1)'(mag_ff) + (MW+1)'(1 << (GUARD - 1));
      rad_sh   = rad_full[MW:GUARD];
      sat_now  = |rad_sh[RW-1:RADIUS_BITS];
      asum     = {1'b0, z32_ff} + (33'd1 << (31 - ANGLE_BITS));
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_r_in    = step_r_ff;
      step_a_in    = step_a_ff;
      cur_r_in     = cur_r_ff;
      cur_a_in     = cur_a_ff;
      op_in        = op_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      have1_in     = have1_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mag_in       = mag_ff;
      z32_in       = z32_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sat_in   = rsp_sat_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_a_in     = rsp_a_ff;
      cc[0]        = '0;
      cx[0]        = '0;
      cy[0]        = '0;
      cz[0]        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               step_r_in = req_step_radius;
               step_a_in = req_step_angle;
               op_in     = OPW'({cur_r_ff, GUARD'(0)});
               phase_in  = PH_POS;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (phase_ff == PH_MAG) begin
               mag_in   = MW'(scaled);
               state_in = S_DONE;
            end else begin
               // exact quarter turn, then the rest of the angle in the chain
               cc[0].valid = 1'b1;
               cc[0].vec   = 1'b0;
               cz[0] = ZW'({ang_sel[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
               case (ang_sel[ANGLE_BITS-1:ANGLE_BITS-2])
                  2'd0:    begin cx[0] = rs;  cy[0] = '0;  end
                  2'd1:    begin cx[0] = '0;  cy[0] = rs;  end
                  2'd2:    begin cx[0] = -rs; cy[0] = '0;  end
                  default: begin cx[0] = '0;  cy[0] = -rs; end
               endcase
               if (phase_ff == PH_POS) begin
                  op_in    = OPW'({step_r_ff, GUARD'(0)});
                  phase_in = PH_STEP;
                  state_in = S_MUL;
               end else begin
                  have1_in = 1'b0;
                  state_in = S_ROT;
               end
            end
         end
         S_ROT: begin
            if (cc[ITERS].valid) begin
               if (!have1_ff) begin
                  x1_in    = cx[ITERS];
                  y1_in    = cy[ITERS];
                  have1_in = 1'b1;
               end else begin
                  sx_in    = x1_ff + cx[ITERS];
                  sy_in    = y1_ff + cy[ITERS];
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (sx_ff == 0 && sy_ff == 0) begin
               mag_in   = '0;
               z32_in   = 32'h0000_0000;
               state_in = S_DONE;
            end else if (sx_ff == 0) begin
               mag_in   = (sy_ff > 0) ? MW'(sy_ff) : MW'(-sy_ff);
               z32_in   = (sy_ff > 0) ? 32'h4000_0000 : 32'hC000_0000;
               state_in = S_DONE;
            end else if (sy_ff == 0) begin
               mag_in   = (sx_ff > 0) ? MW'(sx_ff) : MW'(-sx_ff);
               z32_in   = (sx_ff > 0) ? 32'h0000_0000 : 32'h8000_0000;
               state_in = S_DONE;
            end else begin
               // left half plane: negate and start from a half turn
               cc[0].valid = 1'b1;
               cc[0].vec   = 1'b1;
               if (sx_ff < 0) begin
                  cx[0] = -sx_ff;
                  cy[0] = -sy_ff;
                  cz[0] = ZW'(34'h0_8000_0000);
               end else begin
                  cx[0] = sx_ff;
                  cy[0] = sy_ff;
                  cz[0] = '0;
               end
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            if (cc[ITERS].valid) begin
               op_in    = OPW'(unsigned'(cx[ITERS]));
               z32_in   = cz[ITERS][31:0];
               phase_in = PH_MAG;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cur_r_in     = sat_now ? {RADIUS_BITS{1'b1}} : rad_sh[RADIUS_BITS-1:0];
               cur_a_in     = asum[31:32-ANGLE_BITS];
               rsp_r_in     = cur_r_in;
               rsp_a_in     = cur_a_in;
               rsp_sat_in   = sat_now;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   genvar k;
   generate
      for (k = 0; k < ITERS; k++) begin : g_cell
         ppa_cell #(
            .CW    (CW),
            .ZW    (ZW),
            .SHIFT (k)
         ) u_cell (
            .clock (clock),
            .reset (reset),
            .ctl_i (cc[k]),
            .x_i   (cx[k]),
            .y_i   (cy[k]),
            .z_i   (cz[k]),
            .ctl_o (cc[k+1]),
            .x_o   (cx[k+1]),
            .y_o   (cy[k+1]),
            .z_o   (cz[k+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_POS;
         have1_ff     <= 1'b0;
         cur_r_ff     <= '0;
         cur_a_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         have1_ff     <= have1_in;
         cur_r_ff     <= cur_r_in;
         cur_a_ff     <= cur_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_r_ff  <= step_r_in;
      step_a_ff  <= step_a_in;
      op_ff      <= op_in;
      prod_lo_ff <= 64'(op_ff[31:0]) * 64'(INVK);
      prod_hi_ff <= OPW'(op_ff[OPW-1:32]) * OPW'(INVK);
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      mag_ff     <= mag_in;
      z32_ff     <= z32_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_r_ff   <= rsp_r_in;
      rsp_a_ff   <= rsp_a_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position_radius = rsp_r_ff;
   assign rsp_position_angle  = rsp_a_ff;
   assign rsp_saturated       = rsp_sat_ff;

   a_chain_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cc[ITERS].valid)
      else $error("chain output while idle");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_r_ff == {RADIUS_BITS{1'b1}}))
      else $error("saturated result not clamped");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not presented");

   a_pos_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (cur_r_ff == rsp_r_ff && cur_a_ff == rsp_a_ff))
      else $error("position differs from result");

endmodule
